FILE: hdl/vn4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn4_pkg
// Shared types and constants for the 4D value noise block.
// ----------------------------------------------------------------------------
package vn4_pkg;

	localparam int TABLE_SIZE     = 256;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int COORD_W        = 32;
	localparam int LEVEL_W        = 16;
	localparam int PERM_W         = 8;
	localparam int IDX_IN_W       = 8;
	localparam int QUEUE_DEPTH    = 2;

	typedef enum logic [1:0] {
		CMD_EVAL       = 2'd0,
		CMD_LOAD_LEVEL = 2'd1,
		CMD_LOAD_PERM  = 2'd2,
		CMD_NONE       = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_WAIT,
		ST_LERP,
		ST_DONE
	} eng_state_t;

	// status from engine to the top level
	typedef struct packed {
		logic busy;
		logic result_pending;
	} eng_status_t;

endpackage

FILE: hdl/vn4_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn4_stream_if
// Valid/ready channel carrying a payload of parameterized type.
// ----------------------------------------------------------------------------
interface vn4_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/vn4_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn4_front
// Accepts input transactions, drops unused commands, queues the rest.
// ----------------------------------------------------------------------------
module vn4_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    in_command,
	input  logic [4*vn4_pkg::COORD_W-1:0] in_coords,
	input  logic [vn4_pkg::IDX_IN_W-1:0]  in_index,
	input  logic [vn4_pkg::LEVEL_W-1:0]   in_level,
	input  logic [vn4_pkg::PERM_W-1:0]    in_perm,
	output logic                          q_valid,
	input  logic                          q_pop,
	output logic [1:0]                    q_command,
	output logic [4*vn4_pkg::COORD_W-1:0] q_coords,
	output logic [vn4_pkg::IDX_IN_W-1:0]  q_index,
	output logic [vn4_pkg::LEVEL_W-1:0]   q_level,
	output logic [vn4_pkg::PERM_W-1:0]    q_perm
);
	import vn4_pkg::*;

	localparam int ENT_W = 2 + 4*COORD_W + IDX_IN_W + LEVEL_W + PERM_W;

	logic [ENT_W-1:0] mem_q [QUEUE_DEPTH];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic [ENT_W-1:0] rd;

	assign in_ready = (cnt_q != 2'(QUEUE_DEPTH));
	// unused command consumed without queueing
	assign push = in_valid && in_ready && (cmd_t'(in_command) != CMD_NONE);
	assign q_valid = (cnt_q != 2'd0);
	assign rd = mem_q[rp_q];
	assign {q_command, q_coords, q_index, q_level, q_perm} = rd;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= {in_command, in_coords, in_index, in_level, in_perm};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop && q_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !q_valid) else $error("pop from empty");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'(QUEUE_DEPTH) |=> !push || $past(q_pop)) else $error("push while full");
endmodule

FILE: hdl/vn4_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn4_engine
// Table storage, serial corner lookups and shared interpolation unit.
// ----------------------------------------------------------------------------
module vn4_engine #(
	parameter int FRAC_BITS  = vn4_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  logic [1:0]                    q_command,
	input  logic [4*vn4_pkg::COORD_W-1:0] q_coords,
	input  logic [vn4_pkg::IDX_IN_W-1:0]  q_index,
	input  logic [vn4_pkg::LEVEL_W-1:0]   q_level,
	input  logic [vn4_pkg::PERM_W-1:0]    q_perm,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vn4_pkg::LEVEL_W-1:0]   out_noise,
	output vn4_pkg::eng_status_t          status
);
	import vn4_pkg::*;

	localparam int AW  = $clog2(TABLE_SIZE);
	localparam int DW  = LEVEL_W + 1;
	localparam int PW  = DW + FRAC_BITS + 1;

	logic signed [LEVEL_W-1:0] level_mem [TABLE_SIZE];
	logic        [PERM_W-1:0]  perm_mem  [TABLE_SIZE];

	eng_state_t state_q, state_d;
	logic [3:0] corner_q;   // bit0 x, bit1 y, bit2 z, bit3 t
	logic [2:0] step_q;     // 0..3 perm t,z,y,x ; 4 level
	logic [3:0] lerp_q;
	logic [AW-1:0] addr;
	logic [PERM_W-1:0]  perm_rd_q;
	logic signed [LEVEL_W-1:0] level_rd_q;
	logic [AW-1:0] ix_q, iy_q, iz_q, it_q;
	logic [FRAC_BITS-1:0] fx_q, fy_q, fz_q, ft_q;
	logic signed [LEVEL_W-1:0] val_q [16];
	logic signed [LEVEL_W-1:0] res_q;
	logic out_valid_q;

	logic [4*COORD_W-1:0] c;
	assign c = q_coords;

	// corner index component for the current lookup step
	logic [AW-1:0] base;
	always_comb begin
		unique case (step_q)
			3'd0:    base = it_q + AW'(corner_q[3]);
			3'd1:    base = iz_q + AW'(corner_q[2]);
			3'd2:    base = iy_q + AW'(corner_q[1]);
			3'd3:    base = ix_q + AW'(corner_q[0]);
			default: base = '0;
		endcase
	end
	logic [AW-1:0] prev;
	assign prev = (step_q == 3'd0) ? '0 : perm_rd_q[AW-1:0];
	assign addr = (step_q == 3'd4) ? perm_rd_q[AW-1:0] : AW'(base + prev);

	// interpolation: pairs reduced in place, a=val[ia], b=val[ia+s] with stride s 1, 2, 4, 8 for x, y, z, t
	logic [3:0] ia, ib;
	logic [FRAC_BITS-1:0] fsel;
	logic signed [DW-1:0] diff;
	logic signed [PW-1:0] prod_s1;
	logic signed [LEVEL_W-1:0] a_s1;
	logic [3:0] dst_s1;
	logic       lerp_v_s1;
	always_comb begin
		priority if (lerp_q < 4'd8) begin
			ia = {lerp_q[2:0], 1'b0}; ib = ia + 4'd1; fsel = fx_q;
		end else if (lerp_q < 4'd12) begin
			ia = {lerp_q[1:0], 2'b00}; ib = ia + 4'd2; fsel = fy_q;
		end else if (lerp_q < 4'd14) begin
			ia = {lerp_q[0], 3'b000}; ib = ia + 4'd4; fsel = fz_q;
		end else begin
			ia = 4'd0; ib = 4'd8; fsel = ft_q;
		end
		diff = DW'(val_q[ib]) - DW'(val_q[ia]);
	end

	logic signed [LEVEL_W-1:0] lerp_res;
	assign lerp_res = LEVEL_W'(DW'(a_s1) + DW'(prod_s1 >>> FRAC_BITS));

	logic q_is_eval;
	assign q_is_eval = cmd_t'(q_command) == CMD_EVAL;

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		unique case (state_q)
			ST_IDLE: if (q_valid) begin
				q_pop = 1'b1;
				if (q_is_eval) state_d = ST_LOOK;
			end
			ST_LOOK: if (step_q == 3'd4) state_d = ST_WAIT;
			ST_WAIT: state_d = (corner_q == 4'd15) ? ST_LERP : ST_LOOK;
			ST_LERP: if (lerp_q == 4'd14) state_d = ST_DONE;
			ST_DONE: if (!lerp_v_s1 && !out_valid_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			if (cmd_t'(q_command) == CMD_LOAD_LEVEL) level_mem[q_index[AW-1:0]] <= q_level;
			if (cmd_t'(q_command) == CMD_LOAD_PERM)  perm_mem[q_index[AW-1:0]]  <= q_perm;
			ix_q <= c[FRAC_BITS +: AW];
			iy_q <= c[COORD_W+FRAC_BITS +: AW];
			iz_q <= c[2*COORD_W+FRAC_BITS +: AW];
			it_q <= c[3*COORD_W+FRAC_BITS +: AW];
			fx_q <= c[0 +: FRAC_BITS];
			fy_q <= c[COORD_W +: FRAC_BITS];
			fz_q <= c[2*COORD_W +: FRAC_BITS];
			ft_q <= c[3*COORD_W +: FRAC_BITS];
		end
		if (state_q == ST_LOOK) begin
			if (step_q == 3'd4) level_rd_q <= level_mem[addr];
			else perm_rd_q <= perm_mem[addr];
		end
		if (state_q == ST_WAIT) val_q[corner_q] <= level_rd_q;
		prod_s1 <= PW'(diff) * $signed({1'b0, fsel});
		a_s1    <= val_q[ia];
		dst_s1  <= ia;
		if (lerp_v_s1) begin
			val_q[dst_s1] <= lerp_res;
			res_q <= lerp_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			corner_q    <= '0;
			step_q      <= '0;
			lerp_q      <= '0;
			lerp_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// one lerp in flight at a time: issue only when none is in flight
			lerp_v_s1 <= (state_q == ST_LERP) && !lerp_v_s1;
			if (state_q == ST_LOOK) step_q <= (step_q == 3'd4) ? 3'd0 : step_q + 3'd1;
			if (state_q == ST_WAIT) corner_q <= corner_q + 4'd1;
			if (state_q == ST_LERP && lerp_v_s1) lerp_q <= lerp_q + 4'd1;
			if (state_q == ST_DONE && !lerp_v_s1 && !out_valid_q) lerp_q <= '0;
			if (state_q == ST_DONE && lerp_v_s1) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_noise = res_q;
	assign status.busy = (state_q != ST_IDLE);
	assign status.result_pending = out_valid_q;

	a_noissue: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !q_pop) else $error("pop while busy");
	a_lerp: assert property (@(posedge clk) disable iff (!arst_n)
		lerp_v_s1 |=> !lerp_v_s1) else $error("back to back lerp");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(res_q))
		else $error("result dropped");
endmodule

FILE: hdl/value_noise_4d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_4d
// Four-dimensional lattice value noise with quadrilinear interpolation.
// ----------------------------------------------------------------------------
// Load transactions write one value- or permutation-table entry. An evaluate
// transaction holds the engine: each of the 16 corners needs five chained reads
// of the single-port tables plus a step to store the corner value, then 15
// interpolations run on one shared multiplier, one at a time, and the result is
// handed off through a valid/ready handshake. A two-entry queue in front lets
// new transactions be accepted meanwhile.
// Tables are undefined until loaded.
module value_noise_4d #(
	parameter int FRAC_BITS  = vn4_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	vn4_stream_if.sink   in_ch,
	vn4_stream_if.source out_ch
);
	import vn4_pkg::*;

	logic                   q_valid, q_pop;
	logic [1:0]             q_command;
	logic [4*COORD_W-1:0]   q_coords;
	logic [IDX_IN_W-1:0]    q_index;
	logic [LEVEL_W-1:0]     q_level;
	logic [PERM_W-1:0]      q_perm;
	eng_status_t            status;
	logic [LEVEL_W-1:0]     noise;

	vn4_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_command(in_ch.data.command),
		.in_coords({in_ch.data.coord_t, in_ch.data.coord_z,
			in_ch.data.coord_y, in_ch.data.coord_x}),
		.in_index(in_ch.data.entry_index), .in_level(in_ch.data.entry_level),
		.in_perm(in_ch.data.entry_perm),
		.q_valid(q_valid), .q_pop(q_pop), .q_command(q_command),
		.q_coords(q_coords), .q_index(q_index), .q_level(q_level), .q_perm(q_perm)
	);

	vn4_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_command(q_command),
		.q_coords(q_coords), .q_index(q_index), .q_level(q_level), .q_perm(q_perm),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_noise(noise),
		.status(status)
	);

	assign out_ch.data.noise_out = noise;

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.result_pending |-> status.busy) else $error("result without work");
	a_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> status.result_pending) else $error("stray output");
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!status.busy |-> !out_ch.valid) else $error("output while idle");
endmodule

FILE: sim/tb_value_noise_4d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_value_noise_4d
// Self-checking testbench for the 4D lattice value noise block.
// ----------------------------------------------------------------------------
// Both tables are loaded in full first, so no unwritten entry is ever read.
// A short directed set covers coordinate extremes, table extremes and the
// unused command. Random traffic follows: mostly evaluations, with table
// reloads and unused commands mixed in. The sender works in bursts and the
// receiver stalls in changing patterns. A scoreboard predicts every noise
// value and compares each output transaction in order.
// ----------------------------------------------------------------------------
module tb_value_noise_4d;
	import vn4_pkg::*;

	typedef struct packed {
		cmd_t                        command;
		logic signed [COORD_W-1:0]   coord_x;
		logic signed [COORD_W-1:0]   coord_y;
		logic signed [COORD_W-1:0]   coord_z;
		logic signed [COORD_W-1:0]   coord_t;
		logic        [IDX_IN_W-1:0]  entry_index;
		logic signed [LEVEL_W-1:0]   entry_level;
		logic        [PERM_W-1:0]    entry_perm;
	} noise_req_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] noise_out;
	} noise_res_t;

	class noise_scoreboard;
		logic signed [LEVEL_W-1:0] levels [256];
		logic        [PERM_W-1:0]  perms  [256];
		logic signed [LEVEL_W-1:0] pending_noise [$];
		int errors = 0;

		function logic [7:0] hop(logic [7:0] a);
			return perms[a];
		endfunction

		function longint corner(logic [7:0] x, logic [7:0] y, logic [7:0] z, logic [7:0] t);
			logic [7:0] p;
			p = hop(t);
			p = hop(z + p);
			p = hop(y + p);
			p = hop(x + p);
			return longint'(levels[p]);
		endfunction

		function longint lerp(longint a, longint b, longint f);
			return a + (((b - a) * f) >>> FRAC_BITS_DEF);
		endfunction

		function logic signed [LEVEL_W-1:0] noise_at(noise_req_t r);
			logic [7:0] ix, iy, iz, it, tt;
			longint fx, fy, fz, ft, f0, f1, b0, b1;
			longint v [2];
			ix = r.coord_x[23:16]; fx = longint'(r.coord_x[15:0]);
			iy = r.coord_y[23:16]; fy = longint'(r.coord_y[15:0]);
			iz = r.coord_z[23:16]; fz = longint'(r.coord_z[15:0]);
			it = r.coord_t[23:16]; ft = longint'(r.coord_t[15:0]);
			for (int i = 0; i < 2; i++) begin
				tt = it + 8'(i);
				f0 = lerp(corner(ix, iy, iz, tt), corner(ix + 8'd1, iy, iz, tt), fx);
				f1 = lerp(corner(ix, iy + 8'd1, iz, tt),
					corner(ix + 8'd1, iy + 8'd1, iz, tt), fx);
				b0 = lerp(corner(ix, iy, iz + 8'd1, tt),
					corner(ix + 8'd1, iy, iz + 8'd1, tt), fx);
				b1 = lerp(corner(ix, iy + 8'd1, iz + 8'd1, tt),
					corner(ix + 8'd1, iy + 8'd1, iz + 8'd1, tt), fx);
				v[i] = lerp(lerp(f0, f1, fy), lerp(b0, b1, fy), fz);
			end
			return LEVEL_W'(lerp(v[0], v[1], ft));
		endfunction

		function void note_request(noise_req_t r);
			case (r.command)
				CMD_LOAD_LEVEL: levels[r.entry_index] = r.entry_level;
				CMD_LOAD_PERM:  perms[r.entry_index] = r.entry_perm;
				CMD_EVAL:       pending_noise.push_back(noise_at(r));
				default: ;
			endcase
		endfunction

		function void check_noise(noise_res_t res);
			logic signed [LEVEL_W-1:0] want;
			if (pending_noise.size() == 0) begin
				$display("%0t: unexpected noise_out %0d", $time, res.noise_out);
				errors++;
				return;
			end
			want = pending_noise.pop_front();
			if (res.noise_out !== want) begin
				$display("%0t: noise_out mismatch expected %0d actual %0d",
					$time, want, res.noise_out);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	vn4_stream_if #(.payload_t(noise_req_t)) req_ch ();
	vn4_stream_if #(.payload_t(noise_res_t)) res_ch ();

	value_noise_4d dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch),
		.out_ch (res_ch)
	);

	noise_scoreboard sb = new();
	int idle_cycles = 0;
	localparam int IDLE_LIMIT = 6000;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			sb.note_request(req_ch.data);
		if (res_ch.valid && res_ch.ready)
			sb.check_noise(res_ch.data);
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (arst_n && idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// receiver stall patterns: always ready, coin flip, rare ready
	int stall_mode = 0;
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 300);
		end
		stall_left--;
		case (stall_mode)
			0: res_ch.ready = 1'b1;
			1: res_ch.ready = 1'($urandom_range(0, 1));
			default: res_ch.ready = ($urandom_range(0, 7) == 0);
		endcase
	end

	int burst_left = 0;

	task automatic send_req(noise_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				req_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_ch.data  = r;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic load_entry(cmd_t c, logic [7:0] idx, logic [15:0] lvl, logic [7:0] pv);
		noise_req_t r;
		r = '0;
		r.command = c;
		r.entry_index = idx;
		r.entry_level = lvl;
		r.entry_perm = pv;
		r.coord_x = $urandom(); r.coord_y = $urandom();
		r.coord_z = $urandom(); r.coord_t = $urandom();
		send_req(r);
	endtask

	task automatic eval_at(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] t);
		noise_req_t r;
		r.command = CMD_EVAL;
		r.coord_x = x; r.coord_y = y; r.coord_z = z; r.coord_t = t;
		r.entry_index = 8'($urandom()); r.entry_level = 16'($urandom());
		r.entry_perm = 8'($urandom());
		send_req(r);
	endtask

	task automatic drain();
		while (sb.pending_noise.size() != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return {{8{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, 8'($urandom()), 16'($urandom())};
			2: return {16'($urandom_range(0, 3) - 2), 16'($urandom())};
			default: return {16'($urandom()), ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
		endcase
	endfunction

	initial begin
		noise_req_t r;
		int sent;
		int sel;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		res_ch.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill both tables before any evaluation
		for (int i = 0; i < 256; i++)
			load_entry(CMD_LOAD_PERM, 8'(i), 16'($urandom()), 8'($urandom()));
		for (int i = 0; i < 256; i++)
			load_entry(CMD_LOAD_LEVEL, 8'(i), 16'($urandom()), 8'($urandom()));

		// extremes
		load_entry(CMD_LOAD_LEVEL, 8'd0, 16'h8000, 8'd0);
		load_entry(CMD_LOAD_LEVEL, 8'd255, 16'h7FFF, 8'd255);
		load_entry(CMD_LOAD_PERM, 8'd0, 16'h0000, 8'd255);
		load_entry(CMD_LOAD_PERM, 8'd255, 16'hFFFF, 8'd0);
		eval_at(32'h0, 32'h0, 32'h0, 32'h0);
		eval_at(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		eval_at(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		eval_at(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		eval_at(32'h80000000, 32'h7FFFFFFF, 32'h0000FFFF, 32'hFFFF0000);
		eval_at(32'h00FF8000, 32'hFF00FFFF, 32'h00010000, 32'hFFFF0001);
		r = '0;
		r.command = CMD_NONE;
		r.coord_x = 32'hFFFFFFFF;
		r.entry_index = 8'hFF; r.entry_level = 16'hFFFF; r.entry_perm = 8'hFF;
		send_req(r);
		eval_at(32'h00008000, 32'h00008000, 32'h00008000, 32'h00008000);

		// hold off until the pipeline drains completely
		drain();
		@(negedge clk);

		sent = 0;
		while (sent < 120) begin
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				load_entry(CMD_LOAD_LEVEL, 8'($urandom()), 16'($urandom()), 8'($urandom()));
				sent++;
			end else if (sel < 16) begin
				load_entry(CMD_LOAD_PERM, 8'($urandom()), 16'($urandom()), 8'($urandom()));
				sent++;
			end else if (sel < 20) begin
				r.command = CMD_NONE;
				r.coord_x = $urandom(); r.coord_y = $urandom();
				r.coord_z = $urandom(); r.coord_t = $urandom();
				r.entry_index = 8'($urandom()); r.entry_level = 16'($urandom());
				r.entry_perm = 8'($urandom());
				send_req(r);
			end else begin
				eval_at(rand_coord(), rand_coord(), rand_coord(), rand_coord());
				sent++;
			end
			if (sent == 60) begin
				drain();
				@(negedge clk);
			end
		end

		drain();
		repeat (300) @(negedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
